[rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sorted priority cache
// field widths, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MODE_W    = 2;
  localparam int ID_W      = 16;
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRY_W   = ID_W + KEY_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

[rtl/sorted_priority_cache.sv]
// ----------------------------------------------------------------------------
// sorted_priority_cache: bounded store of id/key entries, highest key first
// circular slot ram walked one entry per cycle by a small sequencer
// ----------------------------------------------------------------------------
// Usage
//   in channel  (in_valid/in_ready): one beat carries mode, entry_id, entry_key.
//   out channel (out_valid/out_ready): one result beat per input beat,
//   carrying status, out_id, out_key and count (entries held afterwards).
//   Clear, insert into a full store, pop or remove on an empty store, and
//   insert into an empty store give their result in the cycle after the beat.
//   Pop reads the head entry from the ram, then gives its result. Insert
//   walks from the tail, moving each lower-key entry down one slot, then
//   writes the new entry; remove by identifier scans entries from the head
//   and then moves each later entry up one slot. The walk is set by the
//   single ram read port: one entry is compared or moved per cycle.
//   One item is in flight at a time: in_ready is high only while the
//   sequencer is idle and the result register is empty or being emptied.
//   A stalled receiver holds the result in the output register and holds
//   off the next input beat.
//   Synchronous reset empties the store and drops any pending result; the
//   slot ram is not cleared, since only live slots are ever used.
// ----------------------------------------------------------------------------
module sorted_priority_cache #(
  parameter int DEPTH = spc_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spc_pkg::MODE_W-1:0]     mode,
  input  logic [spc_pkg::ID_W-1:0]       entry_id,
  input  logic [spc_pkg::KEY_W-1:0]      entry_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spc_pkg::STATUS_W-1:0]   status,
  output logic [spc_pkg::ID_W-1:0]       out_id,
  output logic [spc_pkg::KEY_W-1:0]      out_key,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  import spc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    occ, occ_next;
  logic [CW-1:0]    idx, idx_next;
  logic [ID_W-1:0]  id_r;
  logic [KEY_W-1:0] key_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]  rd_id;
  logic [KEY_W-1:0] rd_key;

  logic             in_fire;
  logic             fin;
  status_t          fin_status;
  logic [ID_W-1:0]  fin_id;
  logic [KEY_W-1:0] fin_key;

  logic [CW:0]      idx_p1, idx_p2, occ_x;
  logic             more1, more2, is_full, none_held, key_lt, id_hit;

  // slot of logical position p counted from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(p);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  spc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id  = ram_rdata[ENTRY_W-1:KEY_W];
  assign rd_key = ram_rdata[KEY_W-1:0];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign idx_p1    = (CW+1)'(idx) + (CW+1)'(1);
  assign idx_p2    = (CW+1)'(idx) + (CW+1)'(2);
  assign occ_x     = (CW+1)'(occ);
  assign more1     = idx_p1 < occ_x;
  assign more2     = idx_p2 < occ_x;
  assign is_full   = occ == CW'(DEPTH);
  assign none_held = occ == '0;
  assign key_lt    = rd_key < key_r;
  assign id_hit    = rd_id == id_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_t'(mode))
            MODE_INSERT: if (!is_full && !none_held) state_next = S_INS;
            MODE_POP:    if (!none_held) state_next = S_POP;
            MODE_REMOVE: if (!none_held) state_next = S_SCAN;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!key_lt) begin
          state_next = S_IDLE;
        end else if (idx == CW'(1)) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_IDLE;
      S_POP:     state_next = S_IDLE;
      S_SCAN: begin
        if (id_hit) begin
          state_next = more1 ? S_SHIFT : S_IDLE;
        end else if (!more1) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: if (!more2) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram control and datapath
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = phys(head, idx);
    ram_wdata  = {id_r, key_r};
    ram_raddr  = '0;
    idx_next   = idx;
    occ_next   = occ;
    head_next  = head;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_id     = '0;
    fin_key    = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_t'(mode))
            MODE_INSERT: begin
              if (is_full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (none_held) begin
                ram_we    = 1'b1;
                ram_waddr = phys(head, '0);
                ram_wdata = {entry_id, entry_key};
                occ_next  = occ + CW'(1);
                fin       = 1'b1;
              end else begin
                ram_raddr = phys(head, occ - CW'(1));
                idx_next  = occ;
              end
            end
            MODE_POP: begin
              if (none_held) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else begin
                ram_raddr = phys(head, '0);
              end
            end
            MODE_REMOVE: begin
              if (none_held) begin
                fin        = 1'b1;
                fin_status = STAT_NOTFOUND;
              end else begin
                ram_raddr = phys(head, '0);
                idx_next  = '0;
              end
            end
            default: begin
              head_next = '0;
              occ_next  = '0;
              fin       = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        ram_we = 1'b1;
        if (key_lt) begin
          // move the lower-key entry down one slot
          ram_wdata = ram_rdata;
          idx_next  = idx - CW'(1);
          if (idx != CW'(1)) begin
            ram_raddr = phys(head, idx - CW'(2));
          end
        end else begin
          occ_next = occ + CW'(1);
          fin      = 1'b1;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head, '0);
        occ_next  = occ + CW'(1);
        fin       = 1'b1;
      end
      S_POP: begin
        fin       = 1'b1;
        fin_id    = rd_id;
        fin_key   = rd_key;
        head_next = phys(head, CW'(1));
        occ_next  = occ - CW'(1);
      end
      S_SCAN: begin
        if (id_hit) begin
          if (more1) begin
            ram_raddr = phys(head, idx_p1[CW-1:0]);
          end else begin
            occ_next = occ - CW'(1);
            fin      = 1'b1;
          end
        end else if (more1) begin
          ram_raddr = phys(head, idx_p1[CW-1:0]);
          idx_next  = idx_p1[CW-1:0];
        end else begin
          fin        = 1'b1;
          fin_status = STAT_NOTFOUND;
        end
      end
      S_SHIFT: begin
        // close the gap: entry idx+1 moves up to idx
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_next  = idx_p1[CW-1:0];
        if (more2) begin
          ram_raddr = phys(head, idx_p2[CW-1:0]);
        end else begin
          occ_next = occ - CW'(1);
          fin      = 1'b1;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (in_fire) begin
      id_r  <= entry_id;
      key_r <= entry_key;
    end
    if (fin) begin
      status  <= fin_status;
      out_id  <= fin_id;
      out_key <= fin_key;
      count   <= occ_next;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result pending while sequencer busy");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> more1)
    else $error("shift past last entry");

  a_ins_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (idx != '0) && (occ < CW'(DEPTH)))
    else $error("insert walk out of range");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && (state_next == S_IDLE) |-> fin)
    else $error("item finished without a result");
`endif

endmodule

[rtl/spc_ram.sv]
// ----------------------------------------------------------------------------
// spc_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/sorted_priority_cache_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_cache_tb: self-checking bench for the sorted priority cache
// a behavioural shadow of the sorted store predicts status, popped entry and
// count for every accepted beat; results are compared in order as they leave
// ----------------------------------------------------------------------------
module sorted_priority_cache_tb;
  import spc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    status_t           st;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
  } cache_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode = MODE_INSERT;
  logic [ID_W-1:0]      entry_id = '0;
  logic [KEY_W-1:0]     entry_key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      out_id;
  logic [KEY_W-1:0]     out_key;
  logic [CNT_W-1:0]     count;

  // shadow of the store, logical order from head_pos
  logic [ID_W-1:0]      held_ids [DEPTH];
  logic [KEY_W-1:0]     held_keys[DEPTH];
  int                   head_pos = 0;
  int                   held = 0;

  cache_result_t        expected_results[$];
  int                   error_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  sorted_priority_cache #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .entry_id  (entry_id),
    .entry_key (entry_key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_id    (out_id),
    .out_key   (out_key),
    .count     (count)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int slot_of(int pos);
    return (head_pos + pos) % DEPTH;
  endfunction

  function automatic cache_result_t predict_cache_op(mode_t m, logic [ID_W-1:0] id,
                                                     logic [KEY_W-1:0] key);
    cache_result_t r;
    int pos;
    int hit;
    r = '0;
    r.st = STAT_OK;
    case (m)
      MODE_INSERT: begin
        if (held >= DEPTH) begin
          r.st = STAT_FULL;
        end else begin
          // new entry goes behind every key greater or equal
          pos = held;
          while (pos > 0 && held_keys[slot_of(pos - 1)] < key) begin
            held_ids[slot_of(pos)]  = held_ids[slot_of(pos - 1)];
            held_keys[slot_of(pos)] = held_keys[slot_of(pos - 1)];
            pos--;
          end
          held_ids[slot_of(pos)]  = id;
          held_keys[slot_of(pos)] = key;
          held++;
        end
      end
      MODE_POP: begin
        if (held == 0) begin
          r.st = STAT_EMPTY;
        end else begin
          r.id = held_ids[head_pos];
          r.key = held_keys[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
      end
      MODE_REMOVE: begin
        hit = -1;
        for (int k = 0; k < held; k++)
          if (hit < 0 && held_ids[slot_of(k)] == id) hit = k;
        if (hit < 0) begin
          r.st = STAT_NOTFOUND;
        end else begin
          for (int k = hit; k + 1 < held; k++) begin
            held_ids[slot_of(k)]  = held_ids[slot_of(k + 1)];
            held_keys[slot_of(k)] = held_keys[slot_of(k + 1)];
          end
          held--;
        end
      end
      default: begin
        head_pos = 0;
        held = 0;
      end
    endcase
    r.cnt = CNT_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    error_count++;
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, want, got);
  endtask

  task automatic check_result();
    cache_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result beat", '0, KEY_W'(status));
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.st)
      report_mismatch("status", KEY_W'(want.st), KEY_W'(status));
    if (out_id !== want.id)
      report_mismatch("out_id", KEY_W'(want.id), KEY_W'(out_id));
    if (out_key !== want.key) report_mismatch("out_key", want.key, out_key);
    if (count !== want.cnt)
      report_mismatch("count", KEY_W'(want.cnt), KEY_W'(count));
  endtask

  // result side: random back-pressure, every accepted beat checked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(mode_t m, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    entry_id  <= id;
    entry_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_cache_op(m, id, key));
  endtask

  task automatic test_empty_store();
    send_item(MODE_POP, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(MODE_REMOVE, 16'hFFFF, '0);
    send_item(MODE_CLEAR, '0, '0);
  endtask

  task automatic test_fill_order_and_full();
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < DEPTH; i++) begin
      id  = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : (16'h5A00 | ID_W'(i % 7));
      // repeated keys check that ties leave in arrival order
      key = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h8000_0000 + KEY_W'(i % 3);
      send_item(MODE_INSERT, id, key);
    end
    send_item(MODE_INSERT, 16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_removal_paths();
    send_item(MODE_REMOVE, 16'h5A03, 32'hFFFF_FFFF);  // held twice, nearest head goes
    send_item(MODE_REMOVE, 16'h1234, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_REMOVE, 16'h0000, '0);
    send_item(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(int n_items);
    int               roll;
    bit               filling;
    mode_t            m;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      // swing between filling and draining so full and wrapped states occur
      if (i % 48 == 47) filling = ($urandom_range(0, 1) != 0);
      roll = $urandom_range(0, 99);
      id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       key = $urandom;
        1:       key = $urandom_range(0, 7);
        2:       key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: key = $urandom >> $urandom_range(0, 31);
      endcase
      if (roll < 2) begin
        m = MODE_CLEAR;
      end else if (roll < 5) begin
        m = mode_t'($urandom_range(0, 3));
      end else if (roll < (filling ? 60 : 30)) begin
        m = MODE_INSERT;
      end else if (roll < (filling ? 80 : 68)) begin
        m = MODE_POP;
      end else begin
        m = MODE_REMOVE;
        if (held > 0 && $urandom_range(0, 9) < 7)
          id = held_ids[slot_of($urandom_range(0, held - 1))];
      end
      send_item(m, id, key);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 64;
    test_empty_store();
    test_fill_order_and_full();
    test_removal_paths();
    test_random_traffic(200);

    send_idle_pct = 64;
    recv_idle_pct = 14;
    test_random_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
